@@ hdl/cba_pkg.sv @@
// Shared types and constants for the cluster bitmap allocator.
// Holds the action and status codes, the controller state type and the
// command and status bundles passed between the controller and the datapath.
`default_nettype none

package cba_pkg;

	localparam int ACT_W  = 2;
	localparam int IDX_W  = 16;
	localparam int LEN_W  = 17;
	localparam int CNT_W  = 17;
	localparam int STAT_W = 2;

	localparam logic [CNT_W-1:0] COUNT_RESET = 17'd65536;

	typedef logic [ACT_W-1:0] action_t;
	localparam action_t ACT_MARK    = 2'd0;
	localparam action_t ACT_RELEASE = 2'd1;
	localparam action_t ACT_FIND    = 2'd2;

	typedef logic [STAT_W-1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_RANGE = 2'd1;
	localparam status_t ST_NONE  = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_ADDR,
		S_MODIFY,
		S_SCAN,
		S_RESP
	} state_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic div;
		logic addr;
		logic modify;
		logic scan;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic req_ok;
		logic is_find;
		logic scan_done;
	} sts_t;

endpackage

`default_nettype wire

@@ hdl/cba_bitmap_ram.sv @@
// Word-wide storage for the usage bitmap: one write port and one read port
// with registered read data. Uses no package items.
`default_nettype none

module cba_bitmap_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 32,
	parameter int AW    = 11
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/cba_ctrl.sv @@
// Sequencing controller for the cluster bitmap allocator.
// Depends on cba_pkg for the state type and the command and status bundles.
`default_nettype none

module cba_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire cba_pkg::sts_t sts,
	output cba_pkg::cmd_t      cmd
);

	cba_pkg::state_t state_q;
	cba_pkg::state_t state_next;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cba_pkg::S_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			cba_pkg::S_CLEAR: begin
				if (sts.clear_last) state_next = cba_pkg::S_IDLE;
			end
			cba_pkg::S_IDLE: begin
				if (in_valid) state_next = cba_pkg::S_DIV;
			end
			cba_pkg::S_DIV: begin
				state_next = sts.req_ok ? cba_pkg::S_ADDR : cba_pkg::S_RESP;
			end
			cba_pkg::S_ADDR: begin
				state_next = sts.is_find ? cba_pkg::S_SCAN : cba_pkg::S_MODIFY;
			end
			cba_pkg::S_MODIFY: begin
				state_next = cba_pkg::S_RESP;
			end
			cba_pkg::S_SCAN: begin
				if (sts.scan_done) state_next = cba_pkg::S_RESP;
			end
			cba_pkg::S_RESP: begin
				if (!out_valid_q || out_ready) state_next = cba_pkg::S_IDLE;
			end
			default: begin
				state_next = cba_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			cba_pkg::S_CLEAR: begin
				cmd.clear = 1'b1;
			end
			cba_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			cba_pkg::S_DIV: begin
				cmd.div = 1'b1;
			end
			cba_pkg::S_ADDR: begin
				cmd.addr = 1'b1;
			end
			cba_pkg::S_MODIFY: begin
				cmd.modify = 1'b1;
			end
			cba_pkg::S_SCAN: begin
				cmd.scan = 1'b1;
			end
			cba_pkg::S_RESP: begin
				cmd.load_out = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// The result register is freed by the downstream transfer and refilled on load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ hdl/cba_datapath.sv @@
// Datapath of the cluster bitmap allocator: request registers, index split,
// word-at-a-time run search, bitmap update and the result register.
// Depends on cba_pkg and instantiates cba_bitmap_ram.
`default_nettype none

module cba_datapath #(
	parameter int MAX_CLUSTERS = 65536,
	parameter int WORD_BITS    = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cba_pkg::cmd_t                 cmd,
	output cba_pkg::sts_t                      sts,
	input  wire logic                          cfg_wr_en,
	input  wire logic [cba_pkg::CNT_W-1:0]     cfg_wr_data,
	input  wire cba_pkg::action_t              in_action,
	input  wire logic [cba_pkg::IDX_W-1:0]     in_index,
	input  wire logic [cba_pkg::LEN_W-1:0]     in_length,
	output cba_pkg::status_t                   out_status,
	output logic                               out_found,
	output logic [cba_pkg::IDX_W-1:0]          out_start
);

	// The 17-bit cluster count never reaches 131072, so no cluster at or above it
	// is ever scanned; clusters above the 16-bit index range stay free.
	localparam int CLUSTER_SPAN = (MAX_CLUSTERS < 131072) ? MAX_CLUSTERS : 131072;
	localparam int WORD_COUNT   = (CLUSTER_SPAN + WORD_BITS - 1) / WORD_BITS;
	localparam int AW           = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BW           = $clog2(WORD_BITS);
	localparam int DIV_SH       = 24;
	localparam logic [21:0] RECIP = 22'((2**DIV_SH + WORD_BITS - 1) / WORD_BITS);

	logic [cba_pkg::CNT_W-1:0] cnt_q;
	logic [cba_pkg::CNT_W-1:0] count_eff;
	cba_pkg::action_t          act_q;
	logic [cba_pkg::IDX_W-1:0] idx_q;
	logic [cba_pkg::LEN_W-1:0] len_q;
	logic [15:0]               quo_q;
	logic [17:0]               base_q;
	logic [BW-1:0]             lo_q;
	logic [16:0]               run_q;
	logic [AW-1:0]             rd_addr_q;
	logic [AW-1:0]             clr_addr_q;
	cba_pkg::status_t          res_status_q;
	logic                      res_found_q;
	logic [cba_pkg::IDX_W-1:0] res_start_q;
	cba_pkg::status_t          out_status_q;
	logic                      out_found_q;
	logic [cba_pkg::IDX_W-1:0] out_start_q;

	logic [39:0]               prod;
	logic [17:0]               base_next;
	logic [17:0]               rem_next;
	logic [cba_pkg::CNT_W-1:0] room;
	logic                      idx_in_range;
	logic                      req_ok;
	logic [WORD_BITS-1:0]      rdata;
	logic [WORD_BITS-1:0]      wdata;
	logic [WORD_BITS-1:0]      bit_mask;
	logic [AW-1:0]             waddr;
	logic [AW-1:0]             raddr;
	logic                      we;
	logic                      re;
	logic [17:0]               lim;
	logic                      last_word;
	logic [WORD_BITS-1:0]      free;
	logic [WORD_BITS-1:0]      hit;
	logic [17:0]               run_at [WORD_BITS];
	logic [BW-1:0]             hit_pos;
	logic                      any_hit;
	logic [17:0]               start_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= cba_pkg::COUNT_RESET;
		end else if (cfg_wr_en) begin
			cnt_q <= cfg_wr_data;
		end
	end

	assign count_eff = (32'(cnt_q) > 32'(MAX_CLUSTERS)) ? cba_pkg::CNT_W'(MAX_CLUSTERS) : cnt_q;

	// Request checks.
	assign idx_in_range = {1'b0, idx_q} < count_eff;
	assign room         = count_eff - {1'b0, idx_q};

	always_comb begin
		case (act_q)
			cba_pkg::ACT_MARK, cba_pkg::ACT_RELEASE: begin
				req_ok = idx_in_range;
			end
			cba_pkg::ACT_FIND: begin
				req_ok = idx_in_range && (len_q != '0) && (len_q <= room);
			end
			default: begin
				req_ok = 1'b0;
			end
		endcase
	end

	assign sts.req_ok  = req_ok;
	assign sts.is_find = (act_q == cba_pkg::ACT_FIND);

	// Word and bit of the index: multiply by a rounded-up reciprocal, which is
	// exact for every 16-bit index, then take back the word base next cycle.
	assign prod      = 40'(idx_q) * 40'(RECIP);
	assign base_next = 18'(32'(quo_q) * WORD_BITS);
	assign rem_next  = 18'(idx_q) - base_next;

	// Search over the word now at the RAM output.
	assign lim       = 18'(count_eff) - base_q;
	assign last_word = (base_q + 18'(WORD_BITS)) >= 18'(count_eff);

	always_comb begin
		for (int p = 0; p < WORD_BITS; p++) begin
			free[p] = !rdata[p] && (BW'(p) >= lo_q) && (18'(p) < lim);
		end
	end

	// Each position finds the nearest bit at or below it that is not free (occupied or outside
	// the search); without one the run carries on from the previous word.
	always_comb begin
		logic        seen;
		logic [17:0] lastu;
		for (int p = 0; p < WORD_BITS; p++) begin
			seen  = 1'b0;
			lastu = '0;
			for (int q = 0; q <= p; q++) begin
				if (!free[q]) begin
					seen  = 1'b1;
					lastu = 18'(q);
				end
			end
			run_at[p] = seen ? (18'(p) - lastu) : (18'(run_q) + 18'(p + 1));
			hit[p]    = free[p] && (run_at[p] >= 18'(len_q));
		end
	end

	always_comb begin
		hit_pos = '0;
		for (int p = WORD_BITS - 1; p >= 0; p--) begin
			if (hit[p]) hit_pos = BW'(p);
		end
	end

	assign any_hit       = |hit;
	assign start_next    = base_q + 18'(hit_pos) + 18'd1 - 18'(len_q);
	assign sts.scan_done = any_hit || last_word;

	// Bitmap port control.
	assign bit_mask = WORD_BITS'(1) << lo_q;
	assign we       = cmd.clear || cmd.modify;
	assign waddr    = cmd.clear ? clr_addr_q : quo_q[AW-1:0];
	assign wdata    = cmd.clear ? '0 :
	                  (act_q == cba_pkg::ACT_MARK) ? (rdata | bit_mask) : (rdata & ~bit_mask);
	assign re       = cmd.addr || (cmd.scan && !last_word);
	assign raddr    = cmd.addr ? quo_q[AW-1:0] : rd_addr_q;

	assign sts.clear_last = (clr_addr_q == AW'(WORD_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	cba_bitmap_ram #(
		.DEPTH (WORD_COUNT),
		.WIDTH (WORD_BITS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= in_action;
			idx_q <= in_index;
			len_q <= in_length;
		end
		if (cmd.div) begin
			quo_q        <= prod[DIV_SH+15:DIV_SH];
			res_status_q <= cba_pkg::ST_RANGE;
			res_found_q  <= 1'b0;
			res_start_q  <= '0;
		end
		if (cmd.addr) begin
			base_q    <= base_next;
			lo_q      <= rem_next[BW-1:0];
			run_q     <= '0;
			rd_addr_q <= quo_q[AW-1:0] + AW'(1);
		end
		if (cmd.modify) begin
			res_status_q <= cba_pkg::ST_OK;
		end
		if (cmd.scan) begin
			if (any_hit) begin
				res_status_q <= cba_pkg::ST_OK;
				res_found_q  <= 1'b1;
				res_start_q  <= start_next[15:0];
			end else if (last_word) begin
				res_status_q <= cba_pkg::ST_NONE;
			end else begin
				base_q    <= base_q + 18'(WORD_BITS);
				lo_q      <= '0;
				run_q     <= run_at[WORD_BITS-1][16:0];
				rd_addr_q <= rd_addr_q + AW'(1);
			end
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
			out_start_q  <= res_start_q;
		end
	end

	assign out_status = out_status_q;
	assign out_found  = out_found_q;
	assign out_start  = out_start_q;

endmodule

`default_nettype wire

@@ hdl/cluster_bitmap_allocator_core.sv @@
// Mark and release pass through the divide, address, modify and response states; an
// out-of-range request goes from divide to response, and find goes through divide, address
// and scan, one bitmap word per cycle and up to MAX_CLUSTERS/WORD_BITS words (2048 by
// default) per search, then response. Throughput: one item at a time; the next input
// transfer can be taken in the cycle after the result load. After reset a clearing pass
// zeroes every word, one per cycle (2048 by default), with s_axis_tready low.
`default_nettype none

module cluster_bitmap_allocator_core #(
	parameter int MAX_CLUSTERS = 65536,
	parameter int WORD_BITS    = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [16:0] cfg_wr_data,   // cluster_count
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // action[1:0], cluster_index[17:2], run_length[34:18]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata   // status[1:0], found[2], run_start[18:3]
);

	cba_pkg::cmd_t    cmd;
	cba_pkg::sts_t    sts;
	cba_pkg::status_t res_status;
	logic             res_found;
	logic [15:0]      res_start;

	cba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cba_datapath #(
		.MAX_CLUSTERS (MAX_CLUSTERS),
		.WORD_BITS    (WORD_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_action   (s_axis_tdata[1:0]),
		.in_index    (s_axis_tdata[17:2]),
		.in_length   (s_axis_tdata[34:18]),
		.out_status  (res_status),
		.out_found   (res_found),
		.out_start   (res_start)
	);

	assign m_axis_tdata = {5'd0, res_start, res_found, res_status};

endmodule

`default_nettype wire
